// ===== hdl/rpn_regex_residue_evaluator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the residue evaluator
// Shared shorthand for concurrent checks clocked on aclk, reset by aresetn.
// ---------------------------------------------------------------------------
`ifndef RPN_REGEX_RESIDUE_EVALUATOR_MACROS_SVH
`define RPN_REGEX_RESIDUE_EVALUATOR_MACROS_SVH

// same-cycle implication
`define RRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rre check failed");

// next-cycle implication
`define RRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rre check failed");

`endif

// ===== hdl/rre_pkg.sv =====
// ---------------------------------------------------------------------------
// rre_pkg
// Symbol codes, register indexes and verdict codes of the residue evaluator.
// ---------------------------------------------------------------------------
package rre_pkg;

    localparam logic [7:0] SYM_UNION  = 8'h2B;  // '+'
    localparam logic [7:0] SYM_CONCAT = 8'h2E;  // '.'
    localparam logic [7:0] SYM_STAR   = 8'h2A;  // '*'

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_TARGET  = 1'b1;

    localparam logic [6:0] MODULUS_RESET = 7'd2;
    localparam logic [7:0] TARGET_RESET  = 8'd97;

    localparam logic [1:0] VERDICT_NO  = 2'd0;
    localparam logic [1:0] VERDICT_YES = 2'd1;
    localparam logic [1:0] VERDICT_ERR = 2'd2;

endpackage

// ===== hdl/rpn_regex_residue_evaluator.sv =====
// ---------------------------------------------------------------------------
// rpn_regex_residue_evaluator
// A letter is pushed directly; '+' ORs the top two sets; '.' ORs rotated copies
// of one set per element of the other; '*' scans the set, runs a subtract-Euclid
// gcd per nonzero element and fills every g-th residue. A last word adds the
// verdict step before m_tvalid, plus any wait for the previous verdict to drain.
// One word at a time: s_tready is high only in ST_IDLE. Reset (aresetn, synchronous):
// FSM, stack count, error flag, m_tvalid, modulus, target reset; RAM not cleared.
// ---------------------------------------------------------------------------
module rpn_regex_residue_evaluator
    import rre_pkg::*;
#(
    parameter int MAX_MODULUS = 64,
    parameter int STACK_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_wdata,
    // input words
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,
    // results
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] verdict, [7:2] zero
);

    localparam int KW = $clog2(MAX_MODULUS + 1);
    localparam int RW = $clog2(MAX_MODULUS);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int JW = KW + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_SUM, ST_SCAN, ST_GCD,
        ST_FILL, ST_PUSH, ST_END, ST_RD_V, ST_OUT
    } state_t;

    state_t                 state_reg,   state_next;
    logic [CW-1:0]          count_reg,   count_next;
    logic                   err_reg,     err_next;
    logic [6:0]             modulus_reg, modulus_next;
    logic [7:0]             target_reg,  target_next;
    logic [7:0]             sym_reg,     sym_next;
    logic                   last_reg,    last_next;
    logic [MAX_MODULUS-1:0] a_reg,       a_next;
    logic [MAX_MODULUS-1:0] b_reg,       b_next;
    logic [MAX_MODULUS-1:0] res_reg,     res_next;
    logic [RW-1:0]          idx_reg,     idx_next;
    logic [KW-1:0]          g_reg,       g_next;
    logic [KW-1:0]          x_reg,       x_next;
    logic [KW-1:0]          y_reg,       y_next;
    logic [JW-1:0]          j_reg,       j_next;
    logic [1:0]             verdict_reg, verdict_next;
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_data_reg,  m_data_next;

    logic [KW-1:0]          k;
    logic [MAX_MODULUS-1:0] kmask;
    logic [RW-1:0]          last_idx;
    logic [JW-1:0]          j_sum;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [MAX_MODULUS-1:0] rd_data;

    rre_ram #(
        .WIDTH (MAX_MODULUS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (res_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // effective modulus: zero acts as 1, large values saturate
    always_comb begin
        if (modulus_reg == 7'd0) begin
            k = KW'(1);
        end else if (modulus_reg > 7'(MAX_MODULUS)) begin
            k = KW'(MAX_MODULUS);
        end else begin
            k = KW'(modulus_reg);
        end
        for (int i = 0; i < MAX_MODULUS; i++) begin
            kmask[i] = (k > KW'(i));
        end
    end

    assign last_idx = RW'(k - KW'(1));
    assign j_sum    = j_reg + JW'(g_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        modulus_next = modulus_reg;
        target_next  = target_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        idx_next     = idx_reg;
        g_next       = g_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        j_next       = j_reg;
        verdict_next = verdict_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(count_reg);
        rd_en        = 1'b0;
        rd_addr      = AW'(count_reg - CW'(1));

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MODULUS: modulus_next = cfg_wdata[6:0];
                CFG_TARGET:  target_next  = cfg_wdata;
                default:     ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sym_next  = s_tdata;
                    last_next = s_tlast;
                    if (s_tdata == SYM_UNION || s_tdata == SYM_CONCAT) begin
                        if (count_reg < CW'(2)) begin
                            err_next   = 1'b1;
                            state_next = ST_END;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = ST_RD_A;
                        end
                    end else if (s_tdata == SYM_STAR) begin
                        if (count_reg == '0) begin
                            err_next   = 1'b1;
                            state_next = ST_END;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = ST_RD_A;
                        end
                    end else begin
                        // letter: {1 mod k} on a match, else {0}
                        res_next = '0;
                        if (s_tdata == target_reg && k != KW'(1)) begin
                            res_next[1] = 1'b1;
                        end else begin
                            res_next[0] = 1'b1;
                        end
                        state_next = ST_PUSH;
                    end
                end
            end

            ST_RD_A: begin
                a_next = rd_data & kmask;
                if (sym_reg == SYM_STAR) begin
                    count_next = count_reg - CW'(1);
                    g_next     = k;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(count_reg - CW'(2));
                    count_next = count_reg - CW'(2);
                    state_next = ST_RD_B;
                end
            end

            ST_RD_B: begin
                b_next = rd_data & kmask;
                if (sym_reg == SYM_UNION) begin
                    res_next   = a_reg | (rd_data & kmask);
                    state_next = ST_PUSH;
                end else begin
                    res_next   = '0;
                    idx_next   = '0;
                    state_next = ST_SUM;
                end
            end

            // b_reg holds b rotated by idx within k bits
            ST_SUM: begin
                if (a_reg[idx_reg]) begin
                    res_next = res_reg | b_reg;
                end
                b_next = {b_reg[MAX_MODULUS-2:0], b_reg[last_idx]} & kmask;
                if (idx_reg == last_idx) begin
                    state_next = ST_PUSH;
                end else begin
                    idx_next = idx_reg + RW'(1);
                end
            end

            ST_SCAN: begin
                if (a_reg[idx_reg] && idx_reg != '0 && g_reg != KW'(1)) begin
                    x_next     = g_reg;
                    y_next     = KW'(idx_reg);
                    state_next = ST_GCD;
                end else if (idx_reg == last_idx) begin
                    j_next     = '0;
                    res_next   = '0;
                    state_next = ST_FILL;
                end else begin
                    idx_next = idx_reg + RW'(1);
                end
            end

            // subtract Euclid, one step a cycle
            ST_GCD: begin
                if (y_reg == '0 || x_reg == '0) begin
                    g_next = (y_reg == '0) ? x_reg : y_reg;
                    if (idx_reg == last_idx) begin
                        j_next     = '0;
                        res_next   = '0;
                        state_next = ST_FILL;
                    end else begin
                        idx_next   = idx_reg + RW'(1);
                        state_next = ST_SCAN;
                    end
                end else if (x_reg >= y_reg) begin
                    x_next = x_reg - y_reg;
                end else begin
                    y_next = y_reg - x_reg;
                end
            end

            // set every g-th residue below k
            ST_FILL: begin
                res_next[j_reg[RW-1:0]] = 1'b1;
                if (j_sum >= JW'(k)) begin
                    state_next = ST_PUSH;
                end else begin
                    j_next = j_sum;
                end
            end

            ST_PUSH: begin
                if (count_reg >= CW'(STACK_DEPTH)) begin
                    err_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_END;
            end

            ST_END: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (err_reg || count_reg != CW'(1)) begin
                    verdict_next = VERDICT_ERR;
                    state_next   = ST_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_RD_V;
                end
            end

            ST_RD_V: begin
                verdict_next = rd_data[0] ? VERDICT_YES : VERDICT_NO;
                state_next   = ST_OUT;
            end

            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = verdict_reg;
                    count_next   = '0;
                    err_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            err_reg     <= 1'b0;
            modulus_reg <= MODULUS_RESET;
            target_reg  <= TARGET_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            modulus_reg <= modulus_next;
            target_reg  <= target_next;
            m_valid_reg <= m_valid_next;
        end
        sym_reg     <= sym_next;
        last_reg    <= last_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        idx_reg     <= idx_next;
        g_reg       <= g_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        j_reg       <= j_next;
        verdict_reg <= verdict_next;
        m_data_reg  <= m_data_next;
    end

endmodule

// ===== hdl/rre_ram.sv =====
// ---------------------------------------------------------------------------
// rre_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rre_checker.sv =====
// ---------------------------------------------------------------------------
// rre_checker
// Port-level checks on the residue evaluator, bound to the top level.
// ---------------------------------------------------------------------------
`include "rpn_regex_residue_evaluator_macros.svh"

module rre_checker
    import rre_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    `RRE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `RRE_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    // verdict codes run from no up to malformed, pad bits zero
    `RRE_ASSERT_SAME(a_verdict_code, m_tvalid, m_tdata <= {6'd0, VERDICT_ERR})
    // a taken word blocks s_tready and yields no verdict at once
    `RRE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `RRE_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))

endmodule

bind rpn_regex_residue_evaluator rre_checker u_rre_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
